// ----- hw/rtl/ipv4_header_validator_core_assert.svh -----
// Assertion macros for the IPv4 header validator.
`ifndef IPV4_HEADER_VALIDATOR_CORE_ASSERT_SVH
`define IPV4_HEADER_VALIDATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define IHV_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("ipv4 header validator: assertion failed");
`define IHV_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("ipv4 header validator: forbidden condition seen");
`else
`define IHV_ASSERT(label, clk, rst_n, prop)
`define IHV_NEVER(label, clk, rst_n, expr)
`endif

`endif

// ----- hw/rtl/ipv4hv_pkg.sv -----
// Shared types and constants for the IPv4 header validator.
package ipv4hv_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  header_bytes;
        logic [10:0] payload_bytes;
        logic [31:0] source_addr;
        logic [31:0] dest_addr;
        logic [7:0]  protocol_number;
    } t_out_item;

    // Header fields captured so far for the packet in flight
    typedef struct packed {
        logic [3:0]  version;
        logic [5:0]  hdr_len;
        logic [15:0] pkt_len;
        logic [15:0] ones_sum;
        logic [7:0]  proto;
        logic [31:0] src;
        logic [31:0] dst;
    } t_hdr_state;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TOO_SMALL = 3'd1;
    localparam logic [2:0] ST_SANITY    = 3'd2;
    localparam logic [2:0] ST_NOT_V4    = 3'd3;
    localparam logic [2:0] ST_CHECKSUM  = 3'd4;
    localparam logic [2:0] ST_PROTOCOL  = 3'd5;

    localparam int unsigned POS_VER_IHL  = 0;
    localparam int unsigned POS_TLEN_HI  = 2;
    localparam int unsigned POS_TLEN_LO  = 3;
    localparam int unsigned POS_PROTO    = 9;
    localparam int unsigned POS_SRC_BASE = 12;
    localparam int unsigned POS_DST_BASE = 16;
    localparam int unsigned POS_DST_END  = 20;

    localparam logic [5:0]  MIN_HDR_BYTES = 6'd20;
    localparam logic [5:0]  MAX_HDR_BYTES = 6'd60;
    localparam logic [3:0]  IP_VERSION    = 4'd4;
    localparam logic [15:0] SUM_GOOD      = 16'hFFFF;
    localparam logic [7:0]  PROTO_DEFAULT = 8'd6;

endpackage

// ----- hw/rtl/ipv4_header_validator_core.sv -----
// IPv4 header validator: takes a received packet one byte per cycle and
// gives one verdict per packet, on the transfer of the byte flagged last.
// Throughput is one byte per cycle while the result register is free; a
// byte is held in the input register, is folded into the captured header
// state and the 16-bit end-around-carry checksum adder, and on the last
// byte the verdict goes straight into the result register, where it is
// presented until it is taken.
// Non-final bytes keep flowing while a result waits; only a last byte
// waits for the result register to free up.
// Bytes beyond MAX_PACKET_BYTES are ignored until the packet ends.
`include "ipv4_header_validator_core_assert.svh"

module ipv4_header_validator_core #(
    parameter int unsigned MAX_PACKET_BYTES = 2048
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  ipv4hv_pkg::t_in_item  i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output ipv4hv_pkg::t_out_item o_out_item,
    input  logic                  i_cfg_wr_en,
    input  logic [7:0]            i_cfg_wr_data
);

    localparam int unsigned CNT_W = $clog2(MAX_PACKET_BYTES + 1);

    logic                   r_in_valid;
    ipv4hv_pkg::t_in_item   r_in_item;
    logic                   r_out_valid;
    ipv4hv_pkg::t_out_item  r_out_item;
    logic [7:0]             r_accepted_protocol;

    ipv4hv_pkg::t_hdr_state next_state;
    logic [CNT_W-1:0]       next_count;
    ipv4hv_pkg::t_out_item  verdict;

    logic out_free;
    logic take;
    logic in_xfer;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign take       = r_in_valid && (!r_in_item.last_byte || out_free);
    assign o_in_stall = r_in_valid && !take;
    assign in_xfer    = i_in_valid && !o_in_stall;

    ipv4hv_accum #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_item       (r_in_item),
        .o_next       (next_state),
        .o_next_count (next_count)
    );

    ipv4hv_verdict #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_verdict (
        .i_state             (next_state),
        .i_count             (next_count),
        .i_accepted_protocol (r_accepted_protocol),
        .o_result            (verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accepted_protocol <= ipv4hv_pkg::PROTO_DEFAULT;
        end else if (i_cfg_wr_en) begin
            r_accepted_protocol <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take && r_in_item.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && r_in_item.last_byte) begin
            r_out_item <= verdict;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `IHV_ASSERT(a_last_loads_result, i_clk, i_rst_n, take && r_in_item.last_byte |=> r_out_valid)
    `IHV_NEVER(a_stall_only_on_full, i_clk, i_rst_n, o_in_stall && !(r_in_valid && r_in_item.last_byte && r_out_valid && i_out_stall))
    `IHV_NEVER(a_payload_zero_on_fail, i_clk, i_rst_n, r_out_valid && r_out_item.status != ipv4hv_pkg::ST_OK && r_out_item.payload_bytes != 11'd0)
    `IHV_NEVER(a_ok_header_in_range, i_clk, i_rst_n, r_out_valid && r_out_item.status == ipv4hv_pkg::ST_OK && (r_out_item.header_bytes < ipv4hv_pkg::MIN_HDR_BYTES || r_out_item.header_bytes > ipv4hv_pkg::MAX_HDR_BYTES))

endmodule

// ----- hw/rtl/ipv4hv_accum.sv -----
// Per-byte header capture, byte counter and ones-complement header sum.
module ipv4hv_accum #(
    parameter int unsigned MAX_PACKET_BYTES = 2048,
    localparam int unsigned CNT_W = $clog2(MAX_PACKET_BYTES + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_take,
    input  ipv4hv_pkg::t_in_item  i_item,
    output ipv4hv_pkg::t_hdr_state o_next,
    output logic [CNT_W-1:0]      o_next_count
);

    localparam int unsigned PW = (CNT_W > 6) ? CNT_W : 6;

    ipv4hv_pkg::t_hdr_state r_state, n_state;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [7:0]             r_hi_hold, n_hi_hold;

    logic [16:0]            sum_raw;
    logic [PW-1:0]          pos_ext;
    logic [PW-1:0]          hdr_ext;
    logic                   room;

    assign room    = r_count < CNT_W'(MAX_PACKET_BYTES);
    assign pos_ext = PW'(r_count);
    assign hdr_ext = PW'(r_state.hdr_len);
    assign sum_raw = {1'b0, r_state.ones_sum} + {1'b0, r_hi_hold, i_item.data_byte};

    always_comb begin
        n_state   = r_state;
        n_hi_hold = r_hi_hold;
        n_count   = r_count;
        if (room) begin
            n_count = r_count + CNT_W'(1);
            if (r_count == CNT_W'(ipv4hv_pkg::POS_VER_IHL)) begin
                n_state.version = i_item.data_byte[7:4];
                n_state.hdr_len = {i_item.data_byte[3:0], 2'b00};
            end else if (r_count == CNT_W'(ipv4hv_pkg::POS_TLEN_HI)) begin
                n_state.pkt_len[15:8] = i_item.data_byte;
            end else if (r_count == CNT_W'(ipv4hv_pkg::POS_TLEN_LO)) begin
                n_state.pkt_len[7:0] = i_item.data_byte;
            end else if (r_count == CNT_W'(ipv4hv_pkg::POS_PROTO)) begin
                n_state.proto = i_item.data_byte;
            end else if (r_count >= CNT_W'(ipv4hv_pkg::POS_SRC_BASE) &&
                         r_count <  CNT_W'(ipv4hv_pkg::POS_DST_BASE)) begin
                n_state.src = {r_state.src[23:0], i_item.data_byte};
            end else if (r_count >= CNT_W'(ipv4hv_pkg::POS_DST_BASE) &&
                         r_count <  CNT_W'(ipv4hv_pkg::POS_DST_END)) begin
                n_state.dst = {r_state.dst[23:0], i_item.data_byte};
            end

            // even byte opens a word, odd byte closes it; end-around carry
            if (!r_count[0]) begin
                n_hi_hold = i_item.data_byte;
            end else if (pos_ext < hdr_ext) begin
                n_state.ones_sum = sum_raw[15:0] + 16'(sum_raw[16]);
            end
        end
    end

    assign o_next       = n_state;
    assign o_next_count = n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= '0;
            r_count   <= '0;
            r_hi_hold <= '0;
        end else if (i_take) begin
            if (i_item.last_byte) begin
                r_state   <= '0;
                r_count   <= '0;
                r_hi_hold <= '0;
            end else begin
                r_state   <= n_state;
                r_count   <= n_count;
                r_hi_hold <= n_hi_hold;
            end
        end
    end

endmodule

// ----- hw/rtl/ipv4hv_verdict.sv -----
// Ordered header checks and result formatting on the final byte.
module ipv4hv_verdict #(
    parameter int unsigned MAX_PACKET_BYTES = 2048,
    localparam int unsigned CNT_W = $clog2(MAX_PACKET_BYTES + 1)
) (
    input  ipv4hv_pkg::t_hdr_state i_state,
    input  logic [CNT_W-1:0]       i_count,
    input  logic [7:0]             i_accepted_protocol,
    output ipv4hv_pkg::t_out_item  o_result
);

    logic [15:0] count16;
    logic [15:0] hdr16;
    logic [15:0] payload16;
    logic [2:0]  status;

    assign count16   = 16'(i_count);
    assign hdr16     = 16'(i_state.hdr_len);
    assign payload16 = i_state.pkt_len - hdr16;

    always_comb begin
        priority if (count16 < 16'(ipv4hv_pkg::MIN_HDR_BYTES)) begin
            status = ipv4hv_pkg::ST_TOO_SMALL;
        end else if (i_state.hdr_len < ipv4hv_pkg::MIN_HDR_BYTES ||
                     i_state.hdr_len > ipv4hv_pkg::MAX_HDR_BYTES) begin
            status = ipv4hv_pkg::ST_SANITY;
        end else if (hdr16 > count16) begin
            status = ipv4hv_pkg::ST_TOO_SMALL;
        end else if (i_state.version != ipv4hv_pkg::IP_VERSION) begin
            status = ipv4hv_pkg::ST_NOT_V4;
        end else if (i_state.pkt_len < hdr16) begin
            status = ipv4hv_pkg::ST_SANITY;
        end else if (i_state.pkt_len > count16) begin
            status = ipv4hv_pkg::ST_TOO_SMALL;
        end else if (i_state.ones_sum != ipv4hv_pkg::SUM_GOOD) begin
            status = ipv4hv_pkg::ST_CHECKSUM;
        end else if (i_state.proto != i_accepted_protocol) begin
            status = ipv4hv_pkg::ST_PROTOCOL;
        end else begin
            status = ipv4hv_pkg::ST_OK;
        end
    end

    always_comb begin
        o_result.status          = status;
        o_result.header_bytes    = i_state.hdr_len;
        o_result.payload_bytes   = (status == ipv4hv_pkg::ST_OK) ? payload16[10:0] : 11'd0;
        o_result.source_addr     = i_state.src;
        o_result.dest_addr       = i_state.dst;
        o_result.protocol_number = i_state.proto;
    end

endmodule
